>>> hw/rtl/oxygen_window_average_defines.svh
// ---------------------------------------------------------------------------
// oxygen_window_average assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while in reset.
// ---------------------------------------------------------------------------
`ifndef OXYGEN_WINDOW_AVERAGE_DEFINES_SVH
`define OXYGEN_WINDOW_AVERAGE_DEFINES_SVH

// same-cycle implication
`define OWA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("owa assertion failed");

// next-cycle implication
`define OWA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("owa assertion failed");

`endif

>>> hw/rtl/owa_pkg.sv
// ---------------------------------------------------------------------------
// owa_pkg
// Types, constants and codes shared by the oxygen window average block.
// ---------------------------------------------------------------------------
package owa_pkg;

  localparam int MAX_WINDOW = 100;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
  localparam int RAW_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 15;
  localparam int SUM_W      = 22;
  localparam int QUOT_W     = 15;
  localparam int CNT_W      = $clog2(QUOT_W);
  localparam int WLEN_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd11414;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_Q16      = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RD,
    ST_SUB,
    ST_WR,
    ST_DIV,
    ST_DONE
  } owa_state_e;

  typedef struct packed {
    logic [7:0] whole_part;
    logic [7:0] tenths_part;
    logic [7:0] hundredths_part;
  } in_beat_t;

  typedef struct packed {
    logic [14:0] average_centi;
    logic        bad_window;
    logic [6:0]  samples_held;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic rd;
    logic sub;
    logic wr;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic drop;
    logic drop_more;
    logic div_last;
  } dp_stat_t;

endpackage

>>> hw/rtl/owa_datapath.sv
// ---------------------------------------------------------------------------
// owa_datapath
// Reading scaling, sample ring, running sum and serial mean divider.
// ---------------------------------------------------------------------------
`include "oxygen_window_average_defines.svh"

module owa_datapath import owa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  in_beat_t            in_data_i,
  input  logic [GAIN_W-1:0]   gain_i,
  input  logic [WLEN_W-1:0]   wlen_i,
  output out_beat_t           out_data_o
);

  logic [SAMPLE_W-1:0] mem_q [MAX_WINDOW];

  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RAW_W-1:0]    raw_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] rdata_q;
  logic [FILL_W-1:0]   rem_q, rem_d;
  logic [QUOT_W-1:0]   dq_q, dq_d;
  out_beat_t           out_q;

  logic [RAW_W-1:0]          raw_d;
  logic [GAIN_W+RAW_W-1:0]   prod;
  logic [SLOT_W:0]           rd_sum;
  logic [SLOT_W-1:0]         rd_addr;
  logic [SUM_W-1:0]          sum_add;
  logic [FILL_W:0]           trial;
  logic                      trial_ge;

  assign raw_d = RAW_W'(in_data_i.whole_part) * RAW_W'(100)
               + RAW_W'(in_data_i.tenths_part) * RAW_W'(10)
               + RAW_W'(in_data_i.hundredths_part);

  assign prod = (GAIN_W+RAW_W)'(gain_i) * (GAIN_W+RAW_W)'(raw_q);

  // oldest sample still in the mean
  assign rd_sum  = (SLOT_W+1)'(slot_q) + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(fill_q);
  assign rd_addr = (rd_sum >= (SLOT_W+1)'(MAX_WINDOW))
                 ? SLOT_W'(rd_sum - (SLOT_W+1)'(MAX_WINDOW))
                 : SLOT_W'(rd_sum);

  assign sum_add = sum_q + SUM_W'(sample_q);

  // restoring divide, one quotient bit per step
  assign trial    = {rem_q, dq_q[QUOT_W-1]};
  assign trial_ge = trial >= (FILL_W+1)'(fill_q);

  always_comb begin
    fill_d = fill_q;
    slot_d = slot_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    if (cmd_i.sub) begin
      sum_d  = sum_q - SUM_W'(rdata_q);
      fill_d = fill_q - FILL_W'(1);
    end
    if (cmd_i.wr) begin
      sum_d  = sum_add;
      fill_d = fill_q + FILL_W'(1);
      slot_d = (slot_q == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
      rem_d  = sum_add[SUM_W-1:QUOT_W];
      dq_d   = sum_add[QUOT_W-1:0];
      cnt_d  = CNT_W'(QUOT_W - 1);
    end
    if (cmd_i.div_step) begin
      rem_d = trial_ge ? FILL_W'(trial - (FILL_W+1)'(fill_q)) : trial[FILL_W-1:0];
      dq_d  = {dq_q[QUOT_W-2:0], trial_ge};
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      slot_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else begin
      fill_q <= fill_d;
      slot_q <= slot_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    if (cmd_i.load) begin
      raw_q <= raw_d;
    end
    if (cmd_i.mul) begin
      sample_q <= prod[GAIN_W+RAW_W-1:GAIN_W];
    end
    if (cmd_i.out_load) begin
      out_q.average_centi <= stat_o.bad ? '0 : dq_q;
      out_q.bad_window    <= stat_o.bad;
      out_q.samples_held  <= fill_q;
    end
  end

  // sample ring, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[slot_q] <= sample_q;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    stat_o.bad       = (wlen_i == '0) || (wlen_i > WLEN_W'(MAX_WINDOW));
    stat_o.drop      = FILL_W'(fill_q) >= FILL_W'(wlen_i);
    stat_o.drop_more = FILL_W'(fill_q) >  FILL_W'(wlen_i);
    stat_o.div_last  = (cnt_q == '0);
  end

  assign out_data_o = out_q;

  `OWA_ASSERT_IMPL(a_fill_range, 1'b1, fill_q <= FILL_W'(MAX_WINDOW))
  `OWA_ASSERT_IMPL(a_slot_range, 1'b1, slot_q < SLOT_W'(MAX_WINDOW))
  `OWA_ASSERT_IMPL(a_wr_after_drops, cmd_i.wr, fill_q < FILL_W'(wlen_i))
  `OWA_ASSERT_IMPL(a_div_rem_bound, cmd_i.div_step, rem_q < fill_q)
  `OWA_ASSERT_NEXT(a_wr_fill_up, cmd_i.wr, fill_q != '0)

endmodule

>>> hw/rtl/owa_ctrl.sv
// ---------------------------------------------------------------------------
// owa_ctrl
// Sequencer for one reading: scale, drop old samples, insert, divide, hand off.
// ---------------------------------------------------------------------------
module owa_ctrl import owa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  owa_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        priority if (stat_i.bad) state_d = ST_DONE;
        else if (stat_i.drop)    state_d = ST_RD;
        else                     state_d = ST_WR;
      end
      ST_RD: begin
        state_d = ST_SUB;
      end
      ST_SUB: begin
        state_d = stat_i.drop_more ? ST_RD : ST_WR;
      end
      ST_WR: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.rd       = (state_q == ST_RD);
    cmd_o.sub      = (state_q == ST_SUB);
    cmd_o.wr       = (state_q == ST_WR);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.out_load = (state_q == ST_DONE) && out_free;
    in_stall_o     = (state_q != ST_IDLE);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.out_load)        out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/oxygen_window_average.sv
// ---------------------------------------------------------------------------
// oxygen_window_average
// Moving average of calibrated oxygen readings over a programmable window.
// ---------------------------------------------------------------------------
// One reading is taken at a time. A normal reading is scaled by the gain,
// put in the 100-entry sample ring and divided by the fill count in a
// bit-serial restoring divide, one quotient bit at a time; the result is
// handed over once the output register is free, and the next reading is
// accepted the cycle after. Once the window is full, each reading also drops
// the oldest sample through the ring's registered read port, a read state
// and then a subtract state. After the window length is cut, the next
// reading drops every surplus sample the same way. With an illegal window
// length (zero or above 100) the result skips the ring and the divide and
// comes back with the error flag and no state change. The ring needs no
// clearing after reset: only samples written since then are ever read.
module oxygen_window_average import owa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [GAIN_W-1:0] gain_q, gain_d;
  logic [WLEN_W-1:0] wlen_q, wlen_d;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  always_comb begin
    gain_d = gain_q;
    wlen_d = wlen_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_Q16:      gain_d = cfg_data_i[GAIN_W-1:0];
        REG_WINDOW_LENGTH: wlen_d = cfg_data_i[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      wlen_q <= WLEN_RESET;
    end else begin
      gain_q <= gain_d;
      wlen_q <= wlen_d;
    end
  end

  owa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  owa_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .gain_i     (gain_q),
    .wlen_i     (wlen_q),
    .out_data_o (out_data_o)
  );

endmodule
